// File: rtl/qpack_field_section_decoder_macros.svh
// Assertion macros shared by the QPACK field section decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef QPACK_FIELD_SECTION_DECODER_MACROS_SVH
`define QPACK_FIELD_SECTION_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QFSD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QFSD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/qfsd_pkg.sv
// Shared types and constants of the QPACK field section decoder.
// Holds the canonical Huffman code shape; depends on nothing else.
package qfsd_pkg;

	localparam int STATIC_ENTRIES = 99;
	localparam int MAX_CODE_BITS  = 30;
	localparam int HWIN_BITS      = 40;

	// Result kinds.
	localparam logic [2:0] K_FIELD = 3'd0;
	localparam logic [2:0] K_NAME  = 3'd1;
	localparam logic [2:0] K_NCHAR = 3'd2;
	localparam logic [2:0] K_VCHAR = 3'd3;
	localparam logic [2:0] K_EOL   = 3'd4;
	localparam logic [2:0] K_OK    = 3'd5;
	localparam logic [2:0] K_ERR   = 3'd6;

	// Error codes.
	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_DYNAMIC = 3'd1;
	localparam logic [2:0] E_INDEX   = 3'd2;
	localparam logic [2:0] E_LONGINT = 3'd3;
	localparam logic [2:0] E_TRUNC   = 3'd4;
	localparam logic [2:0] E_FORM    = 3'd5;

	typedef logic [31:0] u32_arr_t [31];

	// Number of codes of each length, index is the length in bits.
	localparam u32_arr_t HUFF_COUNT = '{
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd10, 32'd26, 32'd32, 32'd6, 32'd0,
		32'd5, 32'd3, 32'd2, 32'd6, 32'd2, 32'd3, 32'd0, 32'd0, 32'd0, 32'd3,
		32'd8, 32'd13, 32'd26, 32'd29, 32'd12, 32'd4, 32'd15, 32'd19, 32'd29, 32'd0,
		32'd4};

	function automatic u32_arr_t huff_first_calc();
		u32_arr_t f;
		logic [31:0] fi;
		fi = '0;
		f[0] = '0;
		for (int l = 1; l < 31; l++) begin
			f[l] = fi;
			fi = (fi + HUFF_COUNT[l]) << 1;
		end
		return f;
	endfunction

	function automatic u32_arr_t huff_base_calc();
		u32_arr_t b;
		logic [31:0] bi;
		bi = '0;
		b[0] = '0;
		for (int l = 1; l < 31; l++) begin
			b[l] = bi;
			bi = bi + HUFF_COUNT[l];
		end
		return b;
	endfunction

	localparam u32_arr_t HUFF_FIRST = huff_first_calc();
	localparam u32_arr_t HUFF_BASE  = huff_base_calc();

	// One result word.
	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] idx;
		logic [7:0] ch;
		logic [2:0] err;
	} res_t;

	// Outcome of one code lookup.
	typedef struct packed {
		logic       hit;
		logic [4:0] len;
		logic [8:0] idx;
	} match_t;

endpackage

// File: rtl/qfsd_huff_rom.sv
// Synchronous symbol memory of the canonical Huffman code, with a registered read.
// Depends on nothing but the clock; the address is a rank in canonical order.
module qfsd_huff_rom (
	input  logic       clk,
	input  logic [8:0] addr,
	output logic [8:0] sym
);

	localparam int DEPTH = 257;

	localparam logic [8:0] SYMS [DEPTH] = '{
		9'd48,9'd49,9'd50,9'd97,9'd99,9'd101,9'd105,9'd111,9'd115,9'd116,
		9'd32,9'd37,9'd45,9'd46,9'd47,9'd51,9'd52,9'd53,9'd54,9'd55,9'd56,9'd57,
		9'd61,9'd65,9'd95,9'd98,9'd100,9'd102,9'd103,9'd104,9'd108,9'd109,
		9'd110,9'd112,9'd114,9'd117,
		9'd58,9'd66,9'd67,9'd68,9'd69,9'd70,9'd71,9'd72,9'd73,9'd74,9'd75,9'd76,
		9'd77,9'd78,9'd79,9'd80,9'd81,9'd82,9'd83,9'd84,9'd85,9'd86,9'd87,9'd89,
		9'd106,9'd107,9'd113,9'd118,9'd119,9'd120,9'd121,9'd122,
		9'd38,9'd42,9'd44,9'd59,9'd88,9'd90,
		9'd33,9'd34,9'd40,9'd41,9'd63,
		9'd39,9'd43,9'd124,
		9'd35,9'd62,
		9'd0,9'd36,9'd64,9'd91,9'd93,9'd126,
		9'd94,9'd125,
		9'd60,9'd96,9'd123,
		9'd92,9'd195,9'd208,
		9'd128,9'd130,9'd131,9'd162,9'd184,9'd194,9'd224,9'd226,
		9'd153,9'd161,9'd167,9'd172,9'd176,9'd177,9'd179,9'd209,9'd216,9'd217,
		9'd227,9'd229,9'd230,
		9'd129,9'd132,9'd133,9'd134,9'd136,9'd146,9'd154,9'd156,9'd160,9'd163,
		9'd164,9'd169,9'd170,9'd173,9'd178,9'd181,9'd185,9'd186,
		9'd187,9'd189,9'd190,9'd196,9'd198,9'd228,9'd232,9'd233,
		9'd1,9'd135,9'd137,9'd138,9'd139,9'd140,9'd141,9'd143,9'd147,9'd149,
		9'd150,9'd151,9'd152,9'd155,9'd157,9'd158,9'd165,9'd166,9'd168,
		9'd174,9'd175,9'd180,9'd182,9'd183,9'd188,9'd191,9'd197,9'd231,9'd239,
		9'd9,9'd142,9'd144,9'd145,9'd148,9'd159,9'd171,9'd206,9'd215,9'd225,
		9'd236,9'd237,
		9'd199,9'd207,9'd234,9'd235,
		9'd192,9'd193,9'd200,9'd201,9'd202,9'd205,9'd210,9'd213,9'd218,9'd219,
		9'd238,9'd240,9'd242,9'd243,9'd255,
		9'd203,9'd204,9'd211,9'd212,9'd214,9'd221,9'd222,9'd223,9'd241,9'd244,
		9'd245,9'd246,9'd247,9'd248,9'd250,9'd251,9'd252,9'd253,9'd254,
		9'd2,9'd3,9'd4,9'd5,9'd6,9'd7,9'd8,9'd11,9'd12,9'd14,9'd15,9'd16,9'd17,
		9'd18,9'd19,9'd20,9'd21,9'd23,9'd24,9'd25,9'd26,9'd27,9'd28,9'd29,9'd30,
		9'd31,
		9'd127,9'd220,9'd249,
		9'd10,9'd13,9'd22,9'd256};

	always_ff @(posedge clk) begin
		if (addr < 9'(DEPTH)) begin
			sym <= SYMS[addr];
		end else begin
			sym <= 9'd256;
		end
	end

endmodule

// File: rtl/qfsd_huff_match.sv
// Parallel canonical code matcher over the left-aligned Huffman bit window.
// Depends on qfsd_pkg for the code shape tables and the match_t type.
module qfsd_huff_match
	import qfsd_pkg::*;
(
	input  logic [HWIN_BITS-1:0] win,
	input  logic [5:0]           cnt,
	output match_t               m
);

	// Each length is tested on its own; the shortest hit wins.
	always_comb begin
		logic [31:0] c;
		logic [31:0] off;
		m = '0;
		for (int l = MAX_CODE_BITS; l >= 1; l--) begin
			c   = 32'(win >> (HWIN_BITS - l));
			off = c - HUFF_FIRST[l];
			if (6'(l) <= cnt && c >= HUFF_FIRST[l] && off < HUFF_COUNT[l]) begin
				m.hit = 1'b1;
				m.len = 5'(l);
				m.idx = 9'(HUFF_BASE[l] + off);
			end
		end
	end

endmodule

// File: rtl/qpack_field_section_decoder.sv
// QPACK field section decoder (static table only) with Huffman string decoding.
// Uses qfsd_pkg, qfsd_huff_match, qfsd_huff_rom and the assertion macro header.
//
// The decoder takes one section byte per input word and streams result words:
// static indices, name and value characters, line ends, error words and a
// section status word on the byte flagged section_last. It works on one byte
// at a time. A byte is taken in the idle state, then passes the parser, the
// section-end check and the flush step that hands its last result to the
// output register. A raw string byte adds one string step between the parser
// and the section-end check. A Huffman coded byte adds a final lookup on top
// of that, plus a code match and then a symbol memory read per decoded
// symbol; a final lookup that lands on the end-of-string code adds one more
// symbol memory read. A stall on the output holds the sequencer whenever a
// new result needs room. A new byte is taken while the last result of the
// previous byte still waits at the output. After an error the remaining bytes
// of the section produce no words, and the consumer drops any partial line
// already received.
`include "qpack_field_section_decoder_macros.svh"

module qpack_field_section_decoder
	import qfsd_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       section_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [6:0] static_index,
	output logic [7:0] char_out,
	output logic [2:0] error_code,
	output logic       run_last
);

	// Parser phases.
	localparam logic [3:0] PH_RIC       = 4'd0;
	localparam logic [3:0] PH_RIC_MORE  = 4'd1;
	localparam logic [3:0] PH_BASE      = 4'd2;
	localparam logic [3:0] PH_BASE_MORE = 4'd3;
	localparam logic [3:0] PH_LINE      = 4'd4;
	localparam logic [3:0] PH_IDX_MORE  = 4'd5;
	localparam logic [3:0] PH_NREF_MORE = 4'd6;
	localparam logic [3:0] PH_VLEN      = 4'd7;
	localparam logic [3:0] PH_SLEN_MORE = 4'd8;
	localparam logic [3:0] PH_STRING    = 4'd9;

	// Sequencer steps for one byte.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PARSE = 3'd1;
	localparam logic [2:0] S_HLOOK = 3'd2;
	localparam logic [2:0] S_HSYM  = 3'd3;
	localparam logic [2:0] S_SEND  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_FLUSH = 3'd6;

	localparam int SUM_W = 65;
	localparam logic [SUM_W-1:0] LEN_MASK_W = (65'd1 << LENGTH_BITS) - 65'd1;

	logic [2:0]             st_q, d_st;
	logic [7:0]             byte_q;
	logic                   last_q;
	logic [3:0]             phase_q, d_phase;
	logic [LENGTH_BITS-1:0] acc_q, d_acc;
	logic [5:0]             shift_q, d_shift;
	logic                   sat_q, d_sat;
	logic [LENGTH_BITS-1:0] left_q, d_left;
	logic                   huff_q, d_huff;
	logic [HWIN_BITS-1:0]   hwin_q, d_hwin;
	logic [5:0]             hcnt_q, d_hcnt;
	logic                   stuck_q, d_stuck;
	logic                   inval_q, d_inval;
	logic                   failed_q, d_failed;
	logic [4:0]             mlen_s1;

	logic                   pend_v_q;
	res_t                   pend_q;
	logic                   out_v_q;
	res_t                   out_q;
	logic                   out_last_q;

	logic                   want;
	res_t                   res_n;
	logic                   out_free;
	logic                   adv;
	logic                   accept;

	match_t                 hm;
	logic [8:0]             sym;

	// Continuation byte of a prefix integer.
	logic [SUM_W-1:0]       term;
	logic [SUM_W-1:0]       sum;
	logic                   over;
	logic                   nx_sat;
	logic [LENGTH_BITS-1:0] nx_acc;
	logic [5:0]             nx_shift;
	logic                   nx_long;
	logic                   nx_done;

	qfsd_huff_match u_match (
		.win (hwin_q),
		.cnt (hcnt_q),
		.m   (hm)
	);

	qfsd_huff_rom u_rom (
		.clk  (clk),
		.addr (hm.idx),
		.sym  (sym)
	);

	always_comb begin
		term     = SUM_W'(byte_q[6:0]) << shift_q;
		sum      = SUM_W'(acc_q) + term;
		over     = sum > LEN_MASK_W;
		nx_sat   = sat_q || over;
		nx_acc   = sat_q ? acc_q : (over ? '1 : sum[LENGTH_BITS-1:0]);
		nx_shift = shift_q + 6'd7;
		nx_done  = !byte_q[7];
		nx_long  = byte_q[7] && (nx_shift > 6'd56);
	end

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// One step of the sequencer: next state of the decoder and at most one result.
	always_comb begin
		logic do_finish;
		logic fin_indexed;
		logic do_start;
		logic do_end;
		logic [LENGTH_BITS-1:0] op_acc;
		logic op_sat;

		d_st     = st_q;
		d_phase  = phase_q;
		d_acc    = acc_q;
		d_shift  = shift_q;
		d_sat    = sat_q;
		d_left   = left_q;
		d_huff   = huff_q;
		d_hwin   = hwin_q;
		d_hcnt   = hcnt_q;
		d_stuck  = stuck_q;
		d_inval  = inval_q;
		d_failed = failed_q;
		want     = 1'b0;
		res_n    = '0;
		do_finish   = 1'b0;
		fin_indexed = 1'b0;
		do_start    = 1'b0;
		do_end      = 1'b0;
		op_acc      = nx_acc;
		op_sat      = nx_sat;

		case (st_q)
			S_IDLE: begin
				if (accept) begin
					d_st = S_PARSE;
				end
			end
			S_PARSE: begin
				d_st = S_FIN;
				if (!failed_q) begin
					case (phase_q)
						PH_RIC: begin
							d_acc   = LENGTH_BITS'(byte_q);
							d_shift = '0;
							d_sat   = 1'b0;
							if (byte_q != 8'hFF) begin
								if (byte_q != 8'h00) begin
									want = 1'b1;
									res_n.kind = K_ERR;
									res_n.err  = E_DYNAMIC;
									d_failed   = 1'b1;
								end else begin
									d_phase = PH_BASE;
								end
							end else begin
								d_phase = PH_RIC_MORE;
							end
						end
						PH_RIC_MORE: begin
							d_acc = nx_acc;
							d_sat = nx_sat;
							if (byte_q[7]) begin
								d_shift = nx_shift;
							end
							if (nx_long) begin
								want = 1'b1;
								res_n.kind = K_ERR;
								res_n.err  = E_LONGINT;
								d_failed   = 1'b1;
							end else if (nx_done) begin
								if (nx_sat || nx_acc != '0) begin
									want = 1'b1;
									res_n.kind = K_ERR;
									res_n.err  = E_DYNAMIC;
									d_failed   = 1'b1;
								end else begin
									d_phase = PH_BASE;
								end
							end
						end
						PH_BASE: begin
							d_acc   = LENGTH_BITS'(byte_q[6:0]);
							d_shift = '0;
							d_sat   = 1'b0;
							d_phase = (byte_q[6:0] != 7'h7F) ? PH_LINE : PH_BASE_MORE;
						end
						PH_BASE_MORE: begin
							d_acc = nx_acc;
							d_sat = nx_sat;
							if (byte_q[7]) begin
								d_shift = nx_shift;
							end
							if (nx_long) begin
								want = 1'b1;
								res_n.kind = K_ERR;
								res_n.err  = E_LONGINT;
								d_failed   = 1'b1;
							end else if (nx_done) begin
								d_phase = PH_LINE;
							end
						end
						PH_LINE: begin
							if (byte_q[7]) begin
								if (!byte_q[6]) begin
									want = 1'b1;
									res_n.kind = K_ERR;
									res_n.err  = E_DYNAMIC;
									d_failed   = 1'b1;
								end else begin
									d_acc   = LENGTH_BITS'(byte_q[5:0]);
									d_shift = '0;
									d_sat   = 1'b0;
									if (byte_q[5:0] != 6'h3F) begin
										do_finish   = 1'b1;
										fin_indexed = 1'b1;
										op_acc      = LENGTH_BITS'(byte_q[5:0]);
										op_sat      = 1'b0;
									end else begin
										d_phase = PH_IDX_MORE;
									end
								end
							end else if (byte_q[6]) begin
								if (!byte_q[4]) begin
									want = 1'b1;
									res_n.kind = K_ERR;
									res_n.err  = E_DYNAMIC;
									d_failed   = 1'b1;
								end else begin
									d_acc   = LENGTH_BITS'(byte_q[3:0]);
									d_shift = '0;
									d_sat   = 1'b0;
									if (byte_q[3:0] != 4'hF) begin
										do_finish = 1'b1;
										op_acc    = LENGTH_BITS'(byte_q[3:0]);
										op_sat    = 1'b0;
									end else begin
										d_phase = PH_NREF_MORE;
									end
								end
							end else if (byte_q[5]) begin
								d_inval = 1'b0;
								d_huff  = byte_q[3];
								d_acc   = LENGTH_BITS'(byte_q[2:0]);
								d_shift = '0;
								d_sat   = 1'b0;
								if (byte_q[2:0] != 3'h7) begin
									do_start = 1'b1;
									op_acc   = LENGTH_BITS'(byte_q[2:0]);
									op_sat   = 1'b0;
								end else begin
									d_phase = PH_SLEN_MORE;
								end
							end else begin
								want = 1'b1;
								res_n.kind = K_ERR;
								res_n.err  = E_FORM;
								d_failed   = 1'b1;
							end
						end
						PH_IDX_MORE, PH_NREF_MORE: begin
							d_acc = nx_acc;
							d_sat = nx_sat;
							if (byte_q[7]) begin
								d_shift = nx_shift;
							end
							if (nx_long) begin
								want = 1'b1;
								res_n.kind = K_ERR;
								res_n.err  = E_LONGINT;
								d_failed   = 1'b1;
							end else if (nx_done) begin
								do_finish   = 1'b1;
								fin_indexed = (phase_q == PH_IDX_MORE);
							end
						end
						PH_VLEN: begin
							d_inval = 1'b1;
							d_huff  = byte_q[7];
							d_acc   = LENGTH_BITS'(byte_q[6:0]);
							d_shift = '0;
							d_sat   = 1'b0;
							if (byte_q[6:0] != 7'h7F) begin
								do_start = 1'b1;
								op_acc   = LENGTH_BITS'(byte_q[6:0]);
								op_sat   = 1'b0;
							end else begin
								d_phase = PH_SLEN_MORE;
							end
						end
						PH_SLEN_MORE: begin
							d_acc = nx_acc;
							d_sat = nx_sat;
							if (byte_q[7]) begin
								d_shift = nx_shift;
							end
							if (nx_long) begin
								want = 1'b1;
								res_n.kind = K_ERR;
								res_n.err  = E_LONGINT;
								d_failed   = 1'b1;
							end else if (nx_done) begin
								do_start = 1'b1;
							end
						end
						PH_STRING: begin
							if (huff_q) begin
								if (!stuck_q) begin
									d_hwin = hwin_q | ({byte_q, 32'd0} >> hcnt_q);
									d_hcnt = hcnt_q + 6'd8;
									d_st   = S_HLOOK;
								end else begin
									d_st = S_SEND;
								end
							end else begin
								want = 1'b1;
								res_n.kind = inval_q ? K_VCHAR : K_NCHAR;
								res_n.ch   = byte_q;
								d_st       = S_SEND;
							end
						end
						default: begin
							d_phase = PH_RIC;
						end
					endcase

					// Index check of a completed static reference.
					if (do_finish) begin
						want = 1'b1;
						if (op_sat || op_acc >= LENGTH_BITS'(STATIC_ENTRIES)) begin
							res_n.kind = K_ERR;
							res_n.err  = E_INDEX;
							d_failed   = 1'b1;
						end else begin
							res_n.kind = fin_indexed ? K_FIELD : K_NAME;
							res_n.idx  = op_acc[6:0];
							if (fin_indexed) begin
								d_phase = PH_LINE;
							end else begin
								d_phase = PH_VLEN;
								d_inval = 1'b1;
							end
						end
					end

					// A string length is known: empty strings end at once.
					if (do_start) begin
						d_left  = op_acc;
						d_hwin  = '0;
						d_hcnt  = '0;
						d_stuck = 1'b0;
						if (!op_sat && op_acc == '0) begin
							do_end = 1'b1;
						end else begin
							d_phase = PH_STRING;
						end
					end
				end
			end
			S_HLOOK: begin
				if (hm.hit) begin
					d_st = S_HSYM;
				end else begin
					if (hcnt_q >= 6'(MAX_CODE_BITS)) begin
						d_stuck = 1'b1;
						d_hwin  = '0;
						d_hcnt  = '0;
					end
					d_st = S_SEND;
				end
			end
			S_HSYM: begin
				if (sym[8]) begin
					// The end-of-string code inside a string is a dead end.
					if (hcnt_q >= 6'(MAX_CODE_BITS)) begin
						d_stuck = 1'b1;
						d_hwin  = '0;
						d_hcnt  = '0;
					end
					d_st = S_SEND;
				end else begin
					want = 1'b1;
					res_n.kind = inval_q ? K_VCHAR : K_NCHAR;
					res_n.ch   = sym[7:0];
					d_hcnt = hcnt_q - 6'(mlen_s1);
					d_hwin = hwin_q << mlen_s1;
					d_st   = S_HLOOK;
				end
			end
			S_SEND: begin
				d_st = S_FIN;
				if (!sat_q) begin
					d_left = left_q - 1'b1;
					if (left_q == LENGTH_BITS'(1)) begin
						do_end = 1'b1;
					end
				end
			end
			S_FIN: begin
				d_st = S_FLUSH;
				if (last_q) begin
					if (!failed_q) begin
						want = 1'b1;
						if (phase_q == PH_LINE) begin
							res_n.kind = K_OK;
						end else begin
							res_n.kind = K_ERR;
							res_n.err  = E_TRUNC;
						end
					end
					d_phase  = PH_RIC;
					d_acc    = '0;
					d_shift  = '0;
					d_sat    = 1'b0;
					d_left   = '0;
					d_huff   = 1'b0;
					d_hwin   = '0;
					d_hcnt   = '0;
					d_stuck  = 1'b0;
					d_inval  = 1'b0;
					d_failed = 1'b0;
				end
			end
			S_FLUSH: begin
				d_st = S_IDLE;
			end
			default: begin
				d_st = S_IDLE;
			end
		endcase

		// Close of a name or value string.
		if (do_end) begin
			d_hwin  = '0;
			d_hcnt  = '0;
			d_stuck = 1'b0;
			if (d_inval) begin
				want = 1'b1;
				res_n.kind = K_EOL;
				d_phase = PH_LINE;
				d_inval = 1'b0;
			end else begin
				d_phase = PH_VLEN;
				d_inval = 1'b1;
			end
		end
	end

	// A new result needs room: the held one moves to the output register first.
	always_comb begin
		if (st_q == S_FLUSH) begin
			adv = !pend_v_q || out_free;
		end else begin
			adv = !want || !pend_v_q || out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			phase_q  <= PH_RIC;
			acc_q    <= '0;
			shift_q  <= '0;
			sat_q    <= 1'b0;
			left_q   <= '0;
			huff_q   <= 1'b0;
			hwin_q   <= '0;
			hcnt_q   <= '0;
			stuck_q  <= 1'b0;
			inval_q  <= 1'b0;
			failed_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q <= 1'b0;
			end
			if (adv) begin
				st_q     <= d_st;
				phase_q  <= d_phase;
				acc_q    <= d_acc;
				shift_q  <= d_shift;
				sat_q    <= d_sat;
				left_q   <= d_left;
				huff_q   <= d_huff;
				hwin_q   <= d_hwin;
				hcnt_q   <= d_hcnt;
				stuck_q  <= d_stuck;
				inval_q  <= d_inval;
				failed_q <= d_failed;
				if (st_q == S_FLUSH) begin
					if (pend_v_q) begin
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
					end
				end else if (want) begin
					pend_v_q <= 1'b1;
					if (pend_v_q) begin
						out_v_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			last_q <= section_last;
		end
		if (st_q == S_HLOOK) begin
			mlen_s1 <= hm.len;
		end
		if (adv) begin
			if (st_q == S_FLUSH) begin
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_last_q <= 1'b1;
				end
			end else if (want) begin
				pend_q <= res_n;
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_last_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid    = out_v_q;
	assign kind         = out_q.kind;
	assign static_index = out_q.idx;
	assign char_out     = out_q.ch;
	assign error_code   = out_q.err;
	assign run_last     = out_last_q;

	// No result is left held once a byte is fully handled.
	`QFSD_ASSERT_IMP(a_idle_no_pend, clk, arst_n, st_q == S_IDLE, !pend_v_q,
		"result held while idle")
	// The Huffman window never holds more bits than it has room for.
	`QFSD_ASSERT_IMP(a_hcnt_range, clk, arst_n, 1'b1, hcnt_q <= 6'(HWIN_BITS),
		"Huffman bit count out of range")
	// The end of a section returns the parser to its start.
	`QFSD_ASSERT_NXT(a_section_reset, clk, arst_n, st_q == S_FIN && last_q && adv,
		phase_q == PH_RIC && !failed_q, "section end did not reset the parser")

endmodule
